[rtl/core/mtes_pkg.sv]
// Shared types and constants for the multi-timer expiry scheduler.
`default_nettype none

package mtes_pkg;

   // Fixed field widths of the item channels
   localparam int MODE_W    = 2;
   localparam int IDX_IN_W  = 3;
   localparam int TIMEOUT_W = 24;
   localparam int EVENT_W   = 3;
   localparam int MIN_W     = 8;

   // Reported expiries per tick and the widths of the list that holds them
   localparam int EXP_PTR_W  = 3;
   localparam int CNT_RES_W  = 4;
   localparam logic [CNT_RES_W-1:0] MAX_RESULTS = 4'd8;

   localparam logic [MIN_W-1:0] MIN_TIMEOUT_RESET = 8'd5;

   // Item modes
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_STOP_ALL = 2'd3;

   // Result codes
   localparam logic [EVENT_W-1:0] EV_EXPIRY    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_START_OK  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_TOO_SHORT = 3'd2;
   localparam logic [EVENT_W-1:0] EV_IGNORED   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_STOPPED   = 3'd4;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMD_RSP,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Status from the shared count-down unit
   typedef struct packed {
      logic expired;
      logic stays_running;
   } tick_status_type;

endpackage

`default_nettype wire

[rtl/core/mtes_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mtes_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 8
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic                                      rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/mtes_tick_unit.sv]
// Shared count-down unit: one timer's decrement, expiry test and reload.
`default_nettype none

module mtes_tick_unit #(
   parameter int TICK_WIDTH = 24
) (
   input  wire logic                   active,
   input  wire logic [TICK_WIDTH-1:0]  remaining,
   input  wire logic [TICK_WIDTH-1:0]  period,
   output logic      [TICK_WIDTH-1:0]  remaining_next,
   output mtes_pkg::tick_status_type   status
);

   import mtes_pkg::*;

   logic expired;

   // Remaining of zero or one expires on this tick
   assign expired = active && (remaining[TICK_WIDTH-1:1] == '0);

   // Reload on expiry (zero period means one-shot), else count down
   assign remaining_next       = expired ? period : (remaining - 1'b1);
   assign status.expired       = expired;
   assign status.stays_running = !expired || (period != '0);

endmodule

`default_nettype wire

[rtl/core/multi_timer_expiry_scheduler_unit.sv]
// Top level of the multi-timer expiry scheduler.
`default_nettype none

// A bank of NUM_TIMERS count-down timers driven by tick, start, stop and
// stop-all items. Counts and periods live in two small RAMs that one
// count-down unit walks through, one timer per cycle. A command is
// accepted, then its single result is loaded into the output register
// once that is free. A tick scans every timer (one RAM read port,
// registered read data), then emits its reported expiries one by one,
// with at most eight reported per tick, lowest index first; later
// expiries still reload or stop their timers. Input stall is high whenever
// an item is in progress. The output register lets a new item be accepted
// while the previous result still waits. The RAMs need no clearing after
// reset: a count is only read for a running timer, and every start writes it.
// min_timeout is written through the csr channel, which is always ready.
module multi_timer_expiry_scheduler_unit #(
   parameter int NUM_TIMERS = 8,
   parameter int TICK_WIDTH = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Input items
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [mtes_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [mtes_pkg::IDX_IN_W-1:0]     req_timer_index,
   input  wire logic [mtes_pkg::TIMEOUT_W-1:0]    req_timeout,
   input  wire logic                              req_repeat_req,
   // Result items
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [mtes_pkg::EVENT_W-1:0]      rsp_event_res,
   output logic      [mtes_pkg::IDX_IN_W-1:0]     rsp_event_timer,
   output logic                                   rsp_last,
   // Configuration
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mtes_pkg::MIN_W-1:0]        csr_wdata
);

   import mtes_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [CNT_W-1:0] SCAN_END     = CNT_W'(NUM_TIMERS);
   localparam logic [7:0]       NUM_TIMERS_L = 8'(NUM_TIMERS);

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         scan_ff, scan_in, scan_prev;
   logic [IDX_W-1:0]         cmd_idx, proc_idx;
   logic [NUM_TIMERS-1:0]    running_ff, running_in;
   logic [MIN_W-1:0]         min_timeout_ff;
   logic [TICK_WIDTH-1:0]    cmd_ticks;

   logic cmd_accept, tick_accept, idx_ok, too_short, start_ok, idx_running;
   logic [EVENT_W-1:0]       cmd_res_ff, cmd_res_in;
   logic [IDX_IN_W-1:0]      cmd_timer_ff, cmd_timer_in;

   logic [IDX_IN_W-1:0]      exp_ff [MAX_RESULTS];
   logic [CNT_RES_W-1:0]     exp_cnt_ff, exp_cnt_in;
   logic [EXP_PTR_W-1:0]     emit_ptr_ff, emit_ptr_in;
   logic                     exp_record, emit_last;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0]       rsp_event_res_ff;
   logic [IDX_IN_W-1:0]      rsp_event_timer_ff;
   logic                     rsp_last_ff;
   logic                     out_free;

   logic                     rd_en, proc_en, load_cmd, load_exp;
   logic                     proc_running;
   logic                     rem_wr_en, per_wr_en;
   logic [IDX_W-1:0]         rem_wr_addr;
   logic [TICK_WIDTH-1:0]    rem_wr_data, per_wr_data;
   logic [TICK_WIDTH-1:0]    rem_rd, per_rd, rem_next;
   tick_status_type          tick_status;

   // Count and period storage
   mtes_ram #(.WIDTH(TICK_WIDTH), .DEPTH(NUM_TIMERS)) u_rem_ram (
      .clock   (clock),
      .wr_en   (rem_wr_en),
      .wr_addr (rem_wr_addr),
      .wr_data (rem_wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (rem_rd)
   );

   mtes_ram #(.WIDTH(TICK_WIDTH), .DEPTH(NUM_TIMERS)) u_per_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (cmd_idx),
      .wr_data (per_wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (per_rd)
   );

   // Shared count-down unit
   mtes_tick_unit #(.TICK_WIDTH(TICK_WIDTH)) u_tick_unit (
      .active         (proc_running),
      .remaining      (rem_rd),
      .period         (per_rd),
      .remaining_next (rem_next),
      .status         (tick_status)
   );

   // Command decode
   assign cmd_idx     = IDX_W'(req_timer_index);
   assign cmd_ticks   = TICK_WIDTH'(req_timeout);
   assign idx_ok      = {5'd0, req_timer_index} < NUM_TIMERS_L;
   assign idx_running = idx_ok && running_ff[cmd_idx];
   assign too_short   = cmd_ticks < TICK_WIDTH'(min_timeout_ff);
   assign cmd_accept  = req_valid && !req_stall && (req_mode != MODE_TICK);
   assign tick_accept = req_valid && !req_stall && (req_mode == MODE_TICK);
   assign start_ok    = cmd_accept && (req_mode == MODE_START) && !too_short
                        && idx_ok && !idx_running;

   always_comb begin
      cmd_timer_in = req_timer_index;
      case (req_mode)
         MODE_START: begin
            if (too_short) begin
               cmd_res_in = EV_TOO_SHORT;
            end else if (!idx_ok || idx_running) begin
               cmd_res_in = EV_IGNORED;
            end else begin
               cmd_res_in = EV_START_OK;
            end
         end
         MODE_STOP_ALL: begin
            cmd_res_in   = EV_STOPPED;
            cmd_timer_in = '0;
         end
         default: begin
            cmd_res_in = EV_STOPPED;
         end
      endcase
   end

   // Scan position: timer being read and timer being updated
   assign scan_prev    = scan_ff - 1'b1;
   assign proc_idx     = scan_prev[IDX_W-1:0];
   assign proc_running = proc_en && running_ff[proc_idx];
   assign exp_record   = tick_status.expired && (exp_cnt_ff < MAX_RESULTS);
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign emit_last    = (CNT_RES_W'(emit_ptr_ff) + 1'b1) == exp_cnt_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_accept) begin
               state_in = ST_SCAN;
            end else if (cmd_accept) begin
               state_in = ST_CMD_RSP;
            end
         end
         ST_CMD_RSP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_ff == SCAN_END) begin
               state_in = (exp_cnt_in != '0) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free && emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      proc_en   = 1'b0;
      load_cmd  = 1'b0;
      load_exp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_CMD_RSP: begin
            load_cmd = out_free;
         end
         ST_SCAN: begin
            rd_en   = scan_ff < SCAN_END;
            proc_en = scan_ff != '0;
         end
         ST_EMIT: begin
            load_exp = out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // RAM write ports: starts in idle, count-down writes during the scan
   assign rem_wr_en   = start_ok || proc_running;
   assign rem_wr_addr = start_ok ? cmd_idx : proc_idx;
   assign rem_wr_data = start_ok ? cmd_ticks : rem_next;
   assign per_wr_en   = start_ok;
   assign per_wr_data = req_repeat_req ? cmd_ticks : '0;

   // Running flags, scan counter, expiry list
   always_comb begin
      running_in = running_ff;
      if (cmd_accept) begin
         case (req_mode)
            MODE_START: begin
               if (start_ok) begin
                  running_in[cmd_idx] = 1'b1;
               end
            end
            MODE_STOP: begin
               if (idx_ok) begin
                  running_in[cmd_idx] = 1'b0;
               end
            end
            MODE_STOP_ALL: begin
               running_in = '0;
            end
            default: begin
               running_in = running_ff;
            end
         endcase
      end
      if (proc_running && !tick_status.stays_running) begin
         running_in[proc_idx] = 1'b0;
      end

      scan_in = scan_ff;
      if (tick_accept) begin
         scan_in = '0;
      end else if ((state_ff == ST_SCAN) && (scan_ff != SCAN_END)) begin
         scan_in = scan_ff + 1'b1;
      end

      exp_cnt_in = exp_cnt_ff;
      if (tick_accept) begin
         exp_cnt_in = '0;
      end else if (exp_record) begin
         exp_cnt_in = exp_cnt_ff + 1'b1;
      end

      emit_ptr_in = emit_ptr_ff;
      if (tick_accept) begin
         emit_ptr_in = '0;
      end else if (load_exp) begin
         emit_ptr_in = emit_ptr_ff + 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_cmd || load_exp) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scan_ff        <= '0;
         running_ff     <= '0;
         min_timeout_ff <= MIN_TIMEOUT_RESET;
         exp_cnt_ff     <= '0;
         emit_ptr_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         running_ff   <= running_in;
         exp_cnt_ff   <= exp_cnt_in;
         emit_ptr_ff  <= emit_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            min_timeout_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd_accept) begin
         cmd_res_ff   <= cmd_res_in;
         cmd_timer_ff <= cmd_timer_in;
      end
      if (exp_record) begin
         exp_ff[exp_cnt_ff[EXP_PTR_W-1:0]] <= IDX_IN_W'(proc_idx);
      end
      if (load_cmd) begin
         rsp_event_res_ff   <= cmd_res_ff;
         rsp_event_timer_ff <= cmd_timer_ff;
         rsp_last_ff        <= 1'b1;
      end else if (load_exp) begin
         rsp_event_res_ff   <= EV_EXPIRY;
         rsp_event_timer_ff <= exp_ff[emit_ptr_ff];
         rsp_last_ff        <= emit_last;
      end
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_res   = rsp_event_res_ff;
   assign rsp_event_timer = rsp_event_timer_ff;
   assign rsp_last        = rsp_last_ff;

   // Expiry list never overfills
   a_exp_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      exp_cnt_ff <= MAX_RESULTS)
      else $error("expiry count above limit");

   // Emitting only with something to emit
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (exp_cnt_ff != '0))
      else $error("emit state with empty expiry list");

   // Command results are always the final result of their item
   a_cmd_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res != EV_EXPIRY)) |-> rsp_last)
      else $error("command result without last");

   // The scan ends once the final timer has been updated
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (scan_ff == SCAN_END)) |=> (state_ff != ST_SCAN))
      else $error("scan ran past the last timer");

endmodule

`default_nettype wire
